// ===== sv/lfks_pkg.sv =====
package lfks_pkg;

    // Input action codes
    localparam logic [2:0] ACT_TICK     = 3'd0;
    localparam logic [2:0] ACT_LOAD_COL = 3'd1;
    localparam logic [2:0] ACT_LOAD_TIM = 3'd2;
    localparam logic [2:0] ACT_PLAY     = 3'd3;
    localparam logic [2:0] ACT_STOP     = 3'd4;

    localparam int NUM_LEDS = 5;
    localparam int NUM_CHAN = 15;
    localparam logic [2:0] LAST_LED = 3'd4;
    localparam logic [1:0] LAST_CH  = 2'd2;

    // Datapath operations, one per cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_SUBTICK,
        OP_ADVANCE,
        OP_PLAY,
        OP_STOP,
        OP_RESTORE,
        OP_TIM_RD,
        OP_TIM_CAP,
        OP_COL_RDS,
        OP_COL_RDT,
        OP_COL_CAPT,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_EL_CLR,
        OP_EL_TPS,
        OP_EL_SAVED,
        OP_EL_ADD,
        OP_MUL,
        OP_COL,
        OP_OUT
    } t_op;

    // What a redraw shows
    typedef enum logic [1:0] {
        EM_BLACK,
        EM_TARGET,
        EM_RENDER
    } t_emit;

    typedef struct packed {
        t_op        op;
        logic [2:0] led;
        logic [1:0] ch;
        t_emit      emit;
    } t_cmd;

    typedef struct packed {
        logic [2:0] act;
        logic       sub_zero;
        logic       animating;
        logic       el_ge_dur;
        logic       el_zero;
        logic       fade_bit;
        logic       cue_ends;
        logic       can_resume;
        logic       out_fire;
    } t_stat;

endpackage

// ===== sv/lfks_ctrl.sv =====
module lfks_ctrl #(
    parameter int DIV_STEPS = 30
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  lfks_pkg::t_stat i_stat,
    output lfks_pkg::t_cmd  o_cmd,
    output logic           o_in_stall
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_PLAY, S_STOP, S_ADV, S_RESTORE,
        S_TRD, S_TCAP, S_CRS, S_CRT, S_CCT,
        S_DSTART, S_DSTEP, S_DEND, S_SEND,
        S_TPS, S_LDSAVED, S_ADD,
        S_EMUL, S_ECOL, S_EOUT, S_EWAIT
    } t_state;

    // what follows a redraw or a frame set-up
    typedef enum logic [1:0] {
        NX_IDLE, NX_ADD, NX_SETUP_TPS, NX_TPS_RESUME
    } t_nxt;

    t_state            r_state;
    t_nxt              r_next;
    logic              r_resume;
    logic [2:0]        r_led;
    logic [1:0]        r_ch;
    logic [CNT_W-1:0]  r_cnt;
    lfks_pkg::t_emit   r_emit;

    // command decode
    always_comb begin
        o_cmd.led  = r_led;
        o_cmd.ch   = r_ch;
        o_cmd.emit = r_emit;
        unique case (r_state)
            S_IDLE:    o_cmd.op = i_in_valid ? lfks_pkg::OP_ACCEPT : lfks_pkg::OP_NONE;
            S_DEC:     o_cmd.op = (i_stat.act == lfks_pkg::ACT_TICK) ?
                                  lfks_pkg::OP_SUBTICK : lfks_pkg::OP_NONE;
            S_PLAY:    o_cmd.op = lfks_pkg::OP_PLAY;
            S_STOP:    o_cmd.op = lfks_pkg::OP_STOP;
            S_ADV:     o_cmd.op = lfks_pkg::OP_ADVANCE;
            S_RESTORE: o_cmd.op = lfks_pkg::OP_RESTORE;
            S_TRD:     o_cmd.op = lfks_pkg::OP_TIM_RD;
            S_TCAP:    o_cmd.op = lfks_pkg::OP_TIM_CAP;
            S_CRS:     o_cmd.op = lfks_pkg::OP_COL_RDS;
            S_CRT:     o_cmd.op = lfks_pkg::OP_COL_RDT;
            S_CCT:     o_cmd.op = lfks_pkg::OP_COL_CAPT;
            S_DSTART:  o_cmd.op = lfks_pkg::OP_DIV_START;
            S_DSTEP:   o_cmd.op = lfks_pkg::OP_DIV_STEP;
            S_DEND:    o_cmd.op = lfks_pkg::OP_DIV_END;
            S_SEND:    o_cmd.op = lfks_pkg::OP_EL_CLR;
            S_TPS:     o_cmd.op = lfks_pkg::OP_EL_TPS;
            S_LDSAVED: o_cmd.op = lfks_pkg::OP_EL_SAVED;
            S_ADD:     o_cmd.op = lfks_pkg::OP_EL_ADD;
            S_EMUL:    o_cmd.op = lfks_pkg::OP_MUL;
            S_ECOL:    o_cmd.op = lfks_pkg::OP_COL;
            S_EOUT:    o_cmd.op = lfks_pkg::OP_OUT;
            default:   o_cmd.op = lfks_pkg::OP_NONE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_next   <= NX_IDLE;
            r_resume <= 1'b0;
            r_led    <= '0;
            r_ch     <= '0;
            r_cnt    <= '0;
            r_emit   <= lfks_pkg::EM_BLACK;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_DEC;
                end
                S_DEC: begin
                    r_state <= S_IDLE;
                    if (i_stat.act == lfks_pkg::ACT_TICK) begin
                        if (i_stat.sub_zero && i_stat.animating) begin
                            if (i_stat.el_ge_dur) begin
                                if (i_stat.cue_ends)
                                    r_state <= i_stat.can_resume ? S_RESTORE : S_STOP;
                                else
                                    r_state <= S_ADV;
                            end else if (i_stat.el_zero || i_stat.fade_bit) begin
                                r_emit  <= lfks_pkg::EM_RENDER;
                                r_next  <= NX_ADD;
                                r_led   <= '0;
                                r_ch    <= '0;
                                r_state <= S_EMUL;
                            end else begin
                                r_state <= S_ADD;
                            end
                        end
                    end else if (i_stat.act == lfks_pkg::ACT_PLAY) begin
                        r_state <= S_PLAY;
                    end else if (i_stat.act == lfks_pkg::ACT_STOP) begin
                        r_state <= S_STOP;
                    end
                end
                S_PLAY: begin
                    r_next   <= NX_IDLE;
                    r_state  <= S_TRD;
                end
                S_RESTORE: begin
                    r_next   <= NX_TPS_RESUME;
                    r_resume <= 1'b1;
                    r_state  <= S_TRD;
                end
                S_STOP: begin
                    r_emit  <= lfks_pkg::EM_BLACK;
                    r_next  <= NX_IDLE;
                    r_led   <= '0;
                    r_ch    <= '0;
                    r_state <= S_EMUL;
                end
                S_ADV: begin
                    r_emit  <= lfks_pkg::EM_TARGET;
                    r_next  <= NX_SETUP_TPS;
                    r_led   <= '0;
                    r_ch    <= '0;
                    r_state <= S_EMUL;
                end
                // frame set-up
                S_TRD:  r_state <= S_TCAP;
                S_TCAP: begin
                    r_led   <= '0;
                    r_state <= S_CRS;
                end
                S_CRS: r_state <= S_CRT;
                S_CRT: r_state <= S_CCT;
                S_CCT: begin
                    r_ch    <= '0;
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_cnt   <= '0;
                    r_state <= S_DSTEP;
                end
                S_DSTEP: begin
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) r_state <= S_DEND;
                    else r_cnt <= r_cnt + 1'b1;
                end
                S_DEND: begin
                    if (r_ch == lfks_pkg::LAST_CH) begin
                        if (r_led == lfks_pkg::LAST_LED) begin
                            r_state <= S_SEND;
                        end else begin
                            r_led   <= r_led + 1'b1;
                            r_state <= S_CRS;
                        end
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= S_DSTART;
                    end
                end
                S_SEND: begin
                    if (r_next == NX_TPS_RESUME)
                        r_state <= r_resume ? S_LDSAVED : S_TPS;
                    else
                        r_state <= S_IDLE;
                end
                S_TPS: r_state <= S_IDLE;
                S_LDSAVED: begin
                    r_resume <= 1'b0;
                    r_emit   <= lfks_pkg::EM_RENDER;
                    r_next   <= NX_ADD;
                    r_led    <= '0;
                    r_ch     <= '0;
                    r_state  <= S_EMUL;
                end
                S_ADD: r_state <= S_IDLE;
                // redraw: three channels per LED, then one beat
                S_EMUL: r_state <= S_ECOL;
                S_ECOL: begin
                    if (r_ch == lfks_pkg::LAST_CH) begin
                        r_state <= S_EOUT;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= S_EMUL;
                    end
                end
                S_EOUT: r_state <= S_EWAIT;
                S_EWAIT: begin
                    if (i_stat.out_fire) begin
                        if (r_led == lfks_pkg::LAST_LED) begin
                            unique case (r_next)
                                NX_IDLE: r_state <= S_IDLE;
                                NX_ADD:  r_state <= S_ADD;
                                NX_SETUP_TPS: begin
                                    r_next   <= NX_TPS_RESUME;
                                    r_resume <= 1'b0;
                                    r_state  <= S_TRD;
                                end
                                NX_TPS_RESUME: r_state <= S_IDLE;
                            endcase
                        end else begin
                            r_led   <= r_led + 1'b1;
                            r_ch    <= '0;
                            r_state <= S_EMUL;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/lfks_dp.sv =====
module lfks_dp #(
    parameter int MAX_FRAMES     = 64,
    parameter int TICKS_PER_STEP = 4,
    parameter int FRAC_BITS      = 14
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lfks_pkg::t_cmd  i_cmd,
    output lfks_pkg::t_stat o_stat,
    input  logic [2:0]      i_action,
    input  logic            i_background,
    input  logic [5:0]      i_frame_slot,
    input  logic [2:0]      i_led_slot,
    input  logic [7:0]      i_red_in,
    input  logic [7:0]      i_green_in,
    input  logic [7:0]      i_blue_in,
    input  logic [15:0]     i_frame_ticks,
    input  logic            i_fade,
    input  logic [15:0]     i_cue_length,
    input  logic            i_repeat_req,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output logic [2:0]      o_led_index,
    output logic [15:0]     o_red_out,
    output logic [15:0]     o_green_out,
    output logic [15:0]     o_blue_out,
    output logic            o_last
);

    localparam int SF  = (MAX_FRAMES < 64) ? MAX_FRAMES : 64;
    localparam int CW  = $clog2(MAX_FRAMES + 1);
    localparam int TAW = $clog2(2 * SF);
    localparam int CAW = $clog2(2 * SF * lfks_pkg::NUM_LEDS);
    localparam int DW  = 16 + FRAC_BITS;
    localparam int SW  = (TICKS_PER_STEP > 1) ? $clog2(TICKS_PER_STEP) : 1;

    // frame stores
    logic [23:0] m_col [2 * SF * lfks_pkg::NUM_LEDS];
    logic [16:0] m_tim [2 * SF];
    logic [23:0] r_crd;
    logic [16:0] r_trd;

    // latched item
    logic [2:0]  r_act;
    logic        r_bg_in;
    logic [15:0] r_len;
    logic        r_rep;

    // playback state
    logic [SW-1:0] r_sub;
    logic          r_anim;
    logic [CW-1:0] r_count;
    logic          r_loop;
    logic          r_bg;
    logic [CW-1:0] r_frame;
    logic [15:0]   r_el;
    logic [16:0]   r_timing;
    logic          r_sv_valid;
    logic [CW-1:0] r_sv_count;
    logic          r_sv_loop;
    logic          r_sv_bg;
    logic [CW-1:0] r_sv_frame;
    logic [15:0]   r_sv_el;

    // per-channel frame data
    logic [15:0]   r_start  [lfks_pkg::NUM_CHAN];
    logic [15:0]   r_target [lfks_pkg::NUM_CHAN];
    logic [DW-1:0] r_dmag   [lfks_pkg::NUM_CHAN];
    logic          r_dneg   [lfks_pkg::NUM_CHAN];

    // divider and multiplier
    logic [15:0]    r_rem;
    logic [DW-1:0]  r_q;
    logic           r_neg;
    logic [DW+15:0] r_prod;

    logic          r_o_valid;
    logic [2:0]    r_o_led;
    logic          r_o_last;
    logic [15:0]   r_o_red;
    logic [15:0]   r_o_green;
    logic [15:0]   r_o_blue;

    logic [3:0]     k_base;
    logic [3:0]     k;
    logic [CW:0]    fp1;
    logic           wrap;
    logic           has_next;
    logic [CW-1:0]  nf;
    logic           count0;
    logic [15:0]    dur;
    logic           fade_on;
    logic           el_ge_dur;
    logic [TAW-1:0] cur_tidx;
    logic [TAW-1:0] nxt_tidx;
    logic [TAW-1:0] w_tidx;
    logic [CAW-1:0] w_caddr;
    logic [CAW-1:0] r_caddr;
    logic [15:0]    mag;
    logic [16:0]    rem_sh;
    logic [16:0]    rem_sub;
    logic [15:0]    off;
    logic [15:0]    interp;
    logic [15:0]    col;
    logic [16:0]    el_sum;
    logic [15:0]    clamp_len;

    // frame sequencing
    always_comb begin
        k_base   = {1'b0, i_cmd.led} * 4'd3;
        k        = k_base + {2'b00, i_cmd.ch};
        fp1      = {1'b0, r_frame} + 1'b1;
        wrap     = (fp1 >= {1'b0, r_count});
        has_next = !wrap || r_loop;
        nf       = wrap ? '0 : fp1[CW-1:0];
        count0   = (r_count == '0);
        dur      = r_timing[15:0];
        fade_on  = r_timing[16] && (dur > 16'(TICKS_PER_STEP));
        el_ge_dur = (r_el >= dur);
        el_sum   = {1'b0, r_el} + 17'(TICKS_PER_STEP);
        clamp_len = (r_len > 16'(MAX_FRAMES)) ? 16'(MAX_FRAMES) : r_len;
    end

    // store addressing: frames past the store depth fold to zero
    always_comb begin
        cur_tidx = TAW'(r_bg ? SF : 0) + ((r_frame < CW'(SF)) ? TAW'(r_frame) : '0);
        nxt_tidx = TAW'(r_bg ? SF : 0) + ((nf < CW'(SF)) ? TAW'(nf) : '0);
        w_tidx   = TAW'(i_background ? SF : 0) + TAW'(i_frame_slot);
        w_caddr  = (CAW'(w_tidx) << 2) + CAW'(w_tidx) + CAW'(i_led_slot);
        if (i_cmd.op == lfks_pkg::OP_COL_RDS)
            r_caddr = (CAW'(cur_tidx) << 2) + CAW'(cur_tidx) + CAW'(i_cmd.led);
        else
            r_caddr = (CAW'(nxt_tidx) << 2) + CAW'(nxt_tidx) + CAW'(i_cmd.led);
    end

    // divider step and colour arithmetic
    always_comb begin
        mag     = (r_target[k] < r_start[k]) ? (r_start[k] - r_target[k])
                                              : (r_target[k] - r_start[k]);
        rem_sh  = {r_rem, r_q[DW-1]};
        rem_sub = rem_sh - {1'b0, dur};
        off     = r_prod[FRAC_BITS +: 16];
        interp  = r_dneg[k] ? (r_start[k] - off) : (r_start[k] + off);
        unique case (i_cmd.emit)
            lfks_pkg::EM_BLACK:  col = '0;
            lfks_pkg::EM_TARGET: col = r_target[k];
            default: begin
                if (el_ge_dur) col = r_target[k];
                else if (r_el == '0 || !r_timing[16]) col = r_start[k];
                else col = interp;
            end
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == lfks_pkg::OP_ACCEPT) begin
            if (i_action == lfks_pkg::ACT_LOAD_COL && {1'b0, i_frame_slot} < 7'(SF)
                && i_led_slot < 3'(lfks_pkg::NUM_LEDS))
                m_col[w_caddr] <= {i_red_in, i_green_in, i_blue_in};
            if (i_action == lfks_pkg::ACT_LOAD_TIM && {1'b0, i_frame_slot} < 7'(SF))
                m_tim[w_tidx] <= {i_fade, i_frame_ticks};
        end
        if (i_cmd.op == lfks_pkg::OP_TIM_RD) r_trd <= m_tim[cur_tidx];
        if (i_cmd.op == lfks_pkg::OP_COL_RDS || i_cmd.op == lfks_pkg::OP_COL_RDT)
            r_crd <= m_col[r_caddr];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            lfks_pkg::OP_ACCEPT: begin
                r_act   <= i_action;
                r_bg_in <= i_background;
                r_len   <= i_cue_length;
                r_rep   <= i_repeat_req;
            end
            lfks_pkg::OP_COL_RDT: begin
                for (int c = 0; c < 3; c++)
                    r_start[k_base + 4'(c)] <= count0 ? '0 : {r_crd[23 - 8 * c -: 8], 8'h00};
            end
            lfks_pkg::OP_COL_CAPT: begin
                for (int c = 0; c < 3; c++)
                    r_target[k_base + 4'(c)] <= (count0 || !has_next) ? '0
                                                : {r_crd[23 - 8 * c -: 8], 8'h00};
            end
            lfks_pkg::OP_DIV_START: begin
                r_neg <= (r_target[k] < r_start[k]);
                r_q   <= {mag, {FRAC_BITS{1'b0}}};
                r_rem <= '0;
            end
            lfks_pkg::OP_DIV_STEP: begin
                if (rem_sh >= {1'b0, dur}) begin
                    r_rem <= rem_sub[15:0];
                    r_q   <= {r_q[DW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[15:0];
                    r_q   <= {r_q[DW-2:0], 1'b0};
                end
            end
            lfks_pkg::OP_DIV_END: begin
                r_dmag[k] <= fade_on ? r_q : '0;
                r_dneg[k] <= r_neg;
            end
            lfks_pkg::OP_MUL: r_prod <= r_dmag[k] * r_el;
            lfks_pkg::OP_COL: begin
                unique case (i_cmd.ch)
                    2'd0:    r_o_red   <= col;
                    2'd1:    r_o_green <= col;
                    default: r_o_blue  <= col;
                endcase
            end
            default: ;
        endcase
    end

    // playback control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub      <= SW'(TICKS_PER_STEP - 1);
            r_anim     <= 1'b0;
            r_count    <= '0;
            r_loop     <= 1'b0;
            r_bg       <= 1'b0;
            r_frame    <= '0;
            r_el       <= '0;
            r_timing   <= '0;
            r_sv_valid <= 1'b0;
            r_sv_count <= '0;
            r_sv_loop  <= 1'b0;
            r_sv_bg    <= 1'b0;
            r_sv_frame <= '0;
            r_sv_el    <= '0;
            r_o_valid  <= 1'b0;
            r_o_led    <= '0;
            r_o_last   <= 1'b0;
        end else begin
            if (r_o_valid && !i_out_stall) r_o_valid <= 1'b0;
            unique case (i_cmd.op)
                lfks_pkg::OP_SUBTICK: begin
                    if (r_sub != '0) r_sub <= r_sub - 1'b1;
                    else r_sub <= SW'(TICKS_PER_STEP - 1);
                end
                lfks_pkg::OP_ADVANCE: r_frame <= nf;
                lfks_pkg::OP_PLAY: begin
                    if (r_anim && !r_bg_in && r_bg) begin
                        r_sv_valid <= 1'b1;
                        r_sv_count <= r_count;
                        r_sv_loop  <= r_loop;
                        r_sv_bg    <= r_bg;
                        r_sv_frame <= r_frame;
                        r_sv_el    <= r_el;
                    end
                    r_count <= CW'(clamp_len);
                    r_bg    <= r_bg_in;
                    r_loop  <= r_bg_in | r_rep;
                    r_frame <= '0;
                    r_anim  <= 1'b1;
                end
                lfks_pkg::OP_STOP: begin
                    r_anim     <= 1'b0;
                    r_sv_valid <= 1'b0;
                end
                lfks_pkg::OP_RESTORE: begin
                    r_count    <= r_sv_count;
                    r_loop     <= r_sv_loop;
                    r_bg       <= r_sv_bg;
                    r_frame    <= r_sv_frame;
                    r_sv_valid <= 1'b0;
                end
                lfks_pkg::OP_TIM_CAP: r_timing <= count0 ? '0 : r_trd;
                lfks_pkg::OP_EL_CLR:   r_el <= '0;
                lfks_pkg::OP_EL_TPS:   r_el <= 16'(TICKS_PER_STEP);
                lfks_pkg::OP_EL_SAVED: r_el <= r_sv_el;
                lfks_pkg::OP_EL_ADD:   r_el <= el_sum[16] ? 16'hFFFF : el_sum[15:0];
                lfks_pkg::OP_OUT: begin
                    r_o_valid <= 1'b1;
                    r_o_led   <= i_cmd.led;
                    r_o_last  <= (i_cmd.led == lfks_pkg::LAST_LED);
                end
                default: ;
            endcase
        end
    end

    // status to the sequencer
    always_comb begin
        o_stat.act        = r_act;
        o_stat.sub_zero   = (r_sub == '0);
        o_stat.animating  = r_anim;
        o_stat.el_ge_dur  = el_ge_dur;
        o_stat.el_zero    = (r_el == '0);
        o_stat.fade_bit   = r_timing[16];
        o_stat.cue_ends   = wrap && !r_loop;
        o_stat.can_resume = r_sv_valid && !r_bg;
        o_stat.out_fire   = r_o_valid && !i_out_stall;
    end

    assign o_out_valid = r_o_valid;
    assign o_led_index = r_o_led;
    assign o_last      = r_o_last;
    assign o_red_out   = r_o_red;
    assign o_green_out = r_o_green;
    assign o_blue_out  = r_o_blue;

endmodule

// ===== sv/led_keyframe_fade_sequencer_top.sv =====
// Keyframe fade sequencer for five RGB LEDs. One item is taken at a time; o_in_stall
// stays high until its work and every result beat are done. A redraw emits five beats
// (LED 0 to 4, o_last on LED 4), each held while output stall is high. Starting a cue,
// advancing a frame or resuming a background cue runs a frame set-up, in which the
// bit-serial divider computes the fade step of each of the fifteen colour channels in
// turn; a frame advance also runs its redraw before the set-up.
module led_keyframe_fade_sequencer_top #(
    parameter int MAX_FRAMES     = 64,
    parameter int TICKS_PER_STEP = 4,
    parameter int FRAC_BITS      = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic        i_background,
    input  logic [5:0]  i_frame_slot,
    input  logic [2:0]  i_led_slot,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic [15:0] i_frame_ticks,
    input  logic        i_fade,
    input  logic [15:0] i_cue_length,
    input  logic        i_repeat_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_led_index,
    output logic [15:0] o_red_out,
    output logic [15:0] o_green_out,
    output logic [15:0] o_blue_out,
    output logic        o_last
);

    lfks_pkg::t_cmd  cmd;
    lfks_pkg::t_stat stat;

    lfks_ctrl #(
        .DIV_STEPS (16 + FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    lfks_dp #(
        .MAX_FRAMES     (MAX_FRAMES),
        .TICKS_PER_STEP (TICKS_PER_STEP),
        .FRAC_BITS      (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_action      (i_action),
        .i_background  (i_background),
        .i_frame_slot  (i_frame_slot),
        .i_led_slot    (i_led_slot),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_frame_ticks (i_frame_ticks),
        .i_fade        (i_fade),
        .i_cue_length  (i_cue_length),
        .i_repeat_req  (i_repeat_req),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_led_index   (o_led_index),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out),
        .o_last        (o_last)
    );

endmodule

// ===== sv/lfks_chk.sv =====
module lfks_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_led_index,
    input logic [15:0] o_red_out,
    input logic        o_last
);

    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_red_out)
                                       && $stable(o_led_index))
        else $error("stalled beat changed");

    // no new item while a redraw is in flight
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open during redraw");

    // last marks LED 4 only
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_led_index == 3'd4)))
        else $error("last flag mismatch");

    // a redraw ends after its last beat
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_last |=> !o_out_valid)
        else $error("beat after end of redraw");

    // an accepted item always takes a decode cycle
    a_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item not decoded");

endmodule

bind led_keyframe_fade_sequencer_top lfks_chk u_lfks_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_led_index (o_led_index),
    .o_red_out   (o_red_out),
    .o_last      (o_last)
);

// ===== dv/led_keyframe_fade_sequencer_top_tb.sv =====
`timescale 1ns / 100ps

module led_keyframe_fade_sequencer_top_tb;

    localparam int FRAMES    = 64;
    localparam int TPS       = 4;
    localparam int FRAC      = 14;
    localparam int WDOG_MAX  = 20000;
    localparam int TAIL_WAIT = 1200;

    typedef struct {
        logic [2:0]  led;
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic        last;
    } t_led_beat;

    typedef struct {
        int unsigned count;
        bit          loop;
        bit          bg;
    } t_cue;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_action;
    logic        i_background;
    logic [5:0]  i_frame_slot;
    logic [2:0]  i_led_slot;
    logic [7:0]  i_red_in;
    logic [7:0]  i_green_in;
    logic [7:0]  i_blue_in;
    logic [15:0] i_frame_ticks;
    logic        i_fade;
    logic [15:0] i_cue_length;
    logic        i_repeat_req;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_led_index;
    logic [15:0] o_red_out;
    logic [15:0] o_green_out;
    logic [15:0] o_blue_out;
    logic        o_last;

    led_keyframe_fade_sequencer_top dut (.*);

    always #10 i_clk = ~i_clk;

    // Sequencer shadow state
    logic [23:0] fg_col [FRAMES*5];
    logic [23:0] bg_col [FRAMES*5];
    logic [16:0] fg_tim [FRAMES];
    logic [16:0] bg_tim [FRAMES];
    bit          fg_col_ok [FRAMES];
    bit          bg_col_ok [FRAMES];
    bit          fg_tim_ok [FRAMES];
    bit          bg_tim_ok [FRAMES];
    int unsigned sub_cnt;
    bit          anim;
    t_cue        cue;
    int unsigned frame_no;
    int unsigned elapsed;
    logic [16:0] cur_tim;
    int unsigned start_c [15];
    int unsigned target_c [15];
    longint      delta_c [15];
    bit          saved_ok;
    t_cue        saved_cue;
    int unsigned saved_frame;
    int unsigned saved_el;

    t_led_beat   led_expect_q[$];
    int          err_cnt;
    int          wdog;
    bit          out_stall_en;
    int          out_wait;

    function automatic int unsigned sat_add(int unsigned a, int unsigned b);
        return (a + b > 65535) ? 65535 : a + b;
    endfunction

    function automatic void fetch_colours(ref int unsigned dst[15], input int unsigned fr);
        logic [23:0] c;
        for (int i = 0; i < 5; i++) begin
            c = cue.bg ? bg_col[fr*5+i] : fg_col[fr*5+i];
            dst[i*3]   = c[23:16] << 8;
            dst[i*3+1] = c[15:8] << 8;
            dst[i*3+2] = c[7:0] << 8;
        end
    endfunction

    function automatic longint fade_step(longint diff, int unsigned dur);
        longint mag;
        if (dur == 0) return 0;
        mag = (diff < 0) ? -diff : diff;
        mag = (mag << FRAC) / dur;
        return (diff < 0) ? -mag : mag;
    endfunction

    function automatic void frame_setup();
        int unsigned dur;
        if (!anim) return;
        if (cue.count == 0 || frame_no >= FRAMES) begin
            cur_tim = '0;
            for (int i = 0; i < 15; i++) begin
                start_c[i] = 0;
                target_c[i] = 0;
            end
        end else begin
            cur_tim = cue.bg ? bg_tim[frame_no] : fg_tim[frame_no];
            fetch_colours(start_c, frame_no);
            if (frame_no + 1 < cue.count || cue.loop)
                fetch_colours(target_c, (frame_no + 1) % cue.count);
            else
                for (int i = 0; i < 15; i++) target_c[i] = 0;
        end
        dur = cur_tim[15:0];
        for (int i = 0; i < 15; i++)
            delta_c[i] = (cur_tim[16] && dur > TPS) ?
                fade_step(longint'(target_c[i]) - longint'(start_c[i]), dur) : 0;
        elapsed = 0;
    endfunction

    function automatic void push_redraw(int unsigned c[15]);
        t_led_beat bt;
        for (int i = 0; i < 5; i++) begin
            bt.led  = i[2:0];
            bt.r    = c[i*3][15:0];
            bt.g    = c[i*3+1][15:0];
            bt.b    = c[i*3+2][15:0];
            bt.last = (i == 4);
            led_expect_q.push_back(bt);
        end
    endfunction

    function automatic void push_black();
        int unsigned z[15];
        for (int i = 0; i < 15; i++) z[i] = 0;
        push_redraw(z);
    endfunction

    function automatic void push_render();
        int unsigned c[15];
        longint p, off;
        if (elapsed >= cur_tim[15:0]) begin
            push_redraw(target_c);
        end else if (elapsed == 0 || !cur_tim[16]) begin
            push_redraw(start_c);
        end else begin
            for (int i = 0; i < 15; i++) begin
                p = delta_c[i] * longint'(elapsed);
                off = ((p < 0) ? -p : p) >>> FRAC;
                if (p < 0) off = -off;
                c[i] = int'(longint'(start_c[i]) + off) & 32'hFFFF;
            end
            push_redraw(c);
        end
    endfunction

    function automatic void halt_all();
        anim = 0;
        saved_ok = 0;
        push_black();
    endfunction

    function automatic void tick_step();
        if (sub_cnt != 0) begin
            sub_cnt--;
            return;
        end
        sub_cnt = TPS - 1;
        if (!anim) return;
        if (elapsed >= cur_tim[15:0]) begin
            frame_no++;
            if (frame_no >= cue.count && !cue.loop) begin
                // cue end: resume a parked background cue or go dark
                if (saved_ok && !cue.bg) begin
                    cue = saved_cue;
                    frame_no = saved_frame;
                    saved_ok = 0;
                    frame_setup();
                    elapsed = saved_el;
                    push_render();
                    elapsed = sat_add(elapsed, TPS);
                end else begin
                    halt_all();
                end
                return;
            end
            if (frame_no >= cue.count) frame_no = 0;
            push_redraw(target_c);
            frame_setup();
            elapsed = TPS;
            return;
        end
        if (elapsed == 0 || cur_tim[16]) push_render();
        elapsed = sat_add(elapsed, TPS);
    endfunction

    // Predict results of one accepted item
    function automatic void predict_item(logic [2:0] act, logic bg, logic [5:0] fs, logic [2:0] ls,
                                         logic [23:0] rgb, logic [16:0] tim,
                                         logic [15:0] len, logic rep);
        case (act)
            lfks_pkg::ACT_TICK: tick_step();
            lfks_pkg::ACT_LOAD_COL: if (ls < 5) begin
                if (bg) bg_col[fs*5+ls] = rgb;
                else    fg_col[fs*5+ls] = rgb;
            end
            lfks_pkg::ACT_LOAD_TIM: begin
                if (bg) bg_tim[fs] = tim;
                else    fg_tim[fs] = tim;
            end
            lfks_pkg::ACT_PLAY: begin
                if (anim && !bg && cue.bg) begin
                    saved_cue = cue;
                    saved_frame = frame_no;
                    saved_el = elapsed;
                    saved_ok = 1;
                end
                cue.count = (len > FRAMES) ? FRAMES : len;
                cue.bg = bg;
                cue.loop = bg ? 1'b1 : rep;
                frame_no = 0;
                anim = 1;
                frame_setup();
            end
            lfks_pkg::ACT_STOP: halt_all();
            default: ;
        endcase
    endfunction

    // Send one item after a random gap; valid stays up until the next gap or drain
    task automatic send_item(logic [2:0] act, logic bg, logic [5:0] fs, logic [2:0] ls,
                             logic [23:0] rgb, logic [15:0] ft, logic fd,
                             logic [15:0] len, logic rep);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_background <= bg;
        i_frame_slot <= fs;
        i_led_slot   <= ls;
        i_red_in     <= rgb[23:16];
        i_green_in   <= rgb[15:8];
        i_blue_in    <= rgb[7:0];
        i_frame_ticks <= ft;
        i_fade       <= fd;
        i_cue_length <= len;
        i_repeat_req <= rep;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_item(act, bg, fs, ls, rgb, {fd, ft}, len, rep);
    endtask

    task automatic do_tick();
        send_item(lfks_pkg::ACT_TICK, 1'($urandom), 6'($urandom), 3'($urandom),
                  24'($urandom), 16'($urandom), 1'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic send_stop();
        send_item(lfks_pkg::ACT_STOP, 1'($urandom), 6'($urandom), 3'($urandom),
                  24'($urandom), 16'($urandom), 1'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic load_frame(logic bg, logic [5:0] fs, logic [15:0] ft, logic fd);
        for (int l = 0; l < 5; l++) begin
            send_item(lfks_pkg::ACT_LOAD_COL, bg, fs, l[2:0], 24'($urandom), 16'($urandom),
                      1'($urandom), 16'($urandom), 1'($urandom));
            if (bg) bg_col_ok[fs] = 1; else fg_col_ok[fs] = 1;
        end
        send_item(lfks_pkg::ACT_LOAD_TIM, bg, fs, 3'($urandom), 24'($urandom), ft, fd,
                  16'($urandom), 1'($urandom));
        if (bg) bg_tim_ok[fs] = 1; else fg_tim_ok[fs] = 1;
    endtask

    // Playable length: frames 0..n-1 of the store all written
    function automatic int unsigned ready_len(logic bg);
        int unsigned n;
        n = 0;
        while (n < FRAMES && (bg ? (bg_col_ok[n] && bg_tim_ok[n])
                                 : (fg_col_ok[n] && fg_tim_ok[n]))) n++;
        return n;
    endfunction

    task automatic play_cue(logic bg, logic [15:0] len, logic rep);
        send_item(lfks_pkg::ACT_PLAY, bg, 6'($urandom), 3'($urandom), 24'($urandom),
                  16'($urandom), 1'($urandom), len, rep);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (led_expect_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_loads_and_ignored();
        // extremes of every field, bad LED slots and unused actions
        load_frame(1'b0, 6'd0, 16'd0, 1'b0);
        load_frame(1'b1, 6'd0, 16'd0, 1'b1);
        send_item(lfks_pkg::ACT_LOAD_COL, 1'b0, 6'd63, 3'd4, 24'hFFFFFF, '0, '0, '0, '0);
        send_item(lfks_pkg::ACT_LOAD_COL, 1'b1, 6'd5, 3'd7, 24'h000000, '0, '0, '0, '0);
        send_item(lfks_pkg::ACT_LOAD_TIM, 1'b1, 6'd63, 3'd0, '0, 16'hFFFF, 1'b1, '0, '0);
        send_item(3'd5, 1'b1, 6'd63, 3'd7, 24'hFFFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1);
        send_item(3'd6, '0, '0, '0, '0, '0, '0, '0, '0);
        send_item(3'd7, 1'b1, 6'd63, 3'd7, 24'hFFFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1);
        repeat (4) do_tick();
    endtask

    task automatic test_zero_length();
        // black frame for a zero-length cue, looping and one-shot
        play_cue(1'b0, 16'd0, 1'b1);
        repeat (4) do_tick();
        play_cue(1'b0, 16'd0, 1'b0);
        repeat (4) do_tick();
        send_stop();
    endtask

    task automatic test_fades();
        // fade frames long and short, hold frames, and a clamped length
        load_frame(1'b0, 6'd1, 16'd37, 1'b1);
        load_frame(1'b0, 6'd2, 16'd3, 1'b1);
        load_frame(1'b0, 6'd3, 16'd12, 1'b0);
        load_frame(1'b1, 6'd1, 16'd9, 1'b1);
        play_cue(1'b0, 16'd4, 1'b0);
        repeat (70) do_tick();
        play_cue(1'b0, 16'hFFFF, 1'b1);
        repeat (8) do_tick();
        send_stop();
    endtask

    task automatic test_bg_resume();
        // fg cue over running bg cue, then resume at fg end
        play_cue(1'b1, 16'd2, 1'b0);
        repeat (13) do_tick();
        play_cue(1'b0, 16'd2, 1'b0);
        repeat (52) do_tick();
        wait_drain();
        send_stop();
    endtask

    task automatic test_long_frame();
        // background loop with a frame of the longest duration
        load_frame(1'b1, 6'd2, 16'hFFFF, 1'b1);
        play_cue(1'b1, 16'd3, 1'b0);
        repeat (16) do_tick();
        send_stop();
    endtask

    task automatic test_random();
        int unsigned sel, lim;
        logic bg;
        for (int n = 0; n < 25; n++) begin
            sel = $urandom_range(0, 99);
            bg = 1'($urandom);
            if (sel < 55) begin
                do_tick();
            end else if (sel < 70) begin
                load_frame(bg, 6'($urandom_range(0, 9)),
                           16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40)),
                           1'($urandom));
            end else if (sel < 86) begin
                lim = ready_len(bg);
                // length 0 or within written frames, so never above the clamp at 64
                play_cue(bg, 16'($urandom_range(0, lim)), 1'($urandom));
            end else if (sel < 90) begin
                send_stop();
            end else if (sel < 95) begin
                send_item(3'($urandom_range(5, 7)), 1'($urandom), 6'($urandom),
                          3'($urandom), 24'($urandom), 16'($urandom), 1'($urandom),
                          16'($urandom), 1'($urandom));
            end else begin
                send_item(lfks_pkg::ACT_LOAD_COL, 1'($urandom), 6'($urandom),
                          3'($urandom_range(5, 7)), 24'($urandom), 16'($urandom),
                          1'($urandom), 16'($urandom), 1'($urandom));
            end
            if (n == 12) wait_drain();
        end
    endtask

    // Output stall: after each taken beat, wait a drawn number of cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_wait = 0;
        end else if (o_out_valid && !i_out_stall) begin
            out_wait = out_stall_en ? $urandom_range(0, 8) : 0;
            i_out_stall <= (out_wait != 0);
        end else if (out_wait != 0) begin
            out_wait--;
            i_out_stall <= (out_wait != 0);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_led_beat ex;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (led_expect_q.size() == 0) begin
                $display("%0t: unexpected beat led=%0d rgb=%h %h %h", $time, o_led_index,
                         o_red_out, o_green_out, o_blue_out);
                err_cnt++;
            end else begin
                ex = led_expect_q.pop_front();
                if (ex.led !== o_led_index || ex.r !== o_red_out || ex.g !== o_green_out ||
                    ex.b !== o_blue_out || ex.last !== o_last) begin
                    $display("%0t: mismatch exp led=%0d r=%h g=%h b=%h last=%b", $time,
                             ex.led, ex.r, ex.g, ex.b, ex.last);
                    $display("%0t:          got led=%0d r=%h g=%h b=%h last=%b", $time,
                             o_led_index, o_red_out, o_green_out, o_blue_out, o_last);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog on idle cycles
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("led_keyframe_fade_sequencer_top_tb: errors");
            $finish;
        end
    end

    initial begin
        i_clk = 0; i_rst_n = 0; i_in_valid = 0; i_action = lfks_pkg::ACT_TICK;
        i_background = 0;
        i_frame_slot = 0; i_led_slot = 0; i_red_in = 0; i_green_in = 0; i_blue_in = 0;
        i_frame_ticks = 0; i_fade = 0; i_cue_length = 0; i_repeat_req = 0;
        err_cnt = 0; wdog = 0; out_stall_en = 1;
        sub_cnt = TPS - 1; anim = 0; cue = '{0, 0, 0}; frame_no = 0; elapsed = 0;
        cur_tim = '0; saved_ok = 0; saved_cue = '{0, 0, 0}; saved_frame = 0; saved_el = 0;
        for (int i = 0; i < 15; i++) begin
            start_c[i] = 0; target_c[i] = 0; delta_c[i] = 0;
        end
        for (int i = 0; i < FRAMES; i++) begin
            fg_col_ok[i] = 0; bg_col_ok[i] = 0; fg_tim_ok[i] = 0; bg_tim_ok[i] = 0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_loads_and_ignored();
        test_zero_length();
        out_stall_en = 0;
        test_fades();
        out_stall_en = 1;
        test_bg_resume();
        test_long_frame();
        test_random();

        wait_drain();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (err_cnt == 0 && led_expect_q.size() == 0)
            $display("led_keyframe_fade_sequencer_top_tb: clean");
        else begin
            if (led_expect_q.size() != 0)
                $display("%0t: %0d beats never arrived", $time, led_expect_q.size());
            $display("led_keyframe_fade_sequencer_top_tb: errors");
        end
        $finish;
    end

endmodule
